### rtl/sbcr_pkg.sv
package sbcr_pkg;

	localparam int SBCR_COORD_WIDTH    = 32;
	localparam int SBCR_TIME_FRAC_BITS = 16;

	// Contact normal codes on the result channel.
	typedef enum logic [1:0] {
		NORMAL_POS_X = 2'd0,
		NORMAL_NEG_X = 2'd1,
		NORMAL_POS_Y = 2'd2,
		NORMAL_NEG_Y = 2'd3
	} normal_t;

endpackage

### rtl/sbcr_if.sv
interface sbcr_pair_if #(
	parameter int COORD_WIDTH = sbcr_pkg::SBCR_COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] mover_x;
	logic signed [COORD_WIDTH-1:0] mover_y;
	logic        [COORD_WIDTH-2:0] mover_half_w;
	logic        [COORD_WIDTH-2:0] mover_half_h;
	logic signed [COORD_WIDTH-1:0] mover_vel_x;
	logic signed [COORD_WIDTH-1:0] mover_vel_y;
	logic signed [COORD_WIDTH-1:0] target_x;
	logic signed [COORD_WIDTH-1:0] target_y;
	logic        [COORD_WIDTH-2:0] target_half_w;
	logic        [COORD_WIDTH-2:0] target_half_h;
	logic signed [COORD_WIDTH-1:0] target_vel_x;
	logic signed [COORD_WIDTH-1:0] target_vel_y;

	modport source (
		output valid, mover_x, mover_y, mover_half_w, mover_half_h, mover_vel_x, mover_vel_y,
		       target_x, target_y, target_half_w, target_half_h, target_vel_x, target_vel_y,
		input  ready
	);
	modport sink (
		input  valid, mover_x, mover_y, mover_half_w, mover_half_h, mover_vel_x, mover_vel_y,
		       target_x, target_y, target_half_w, target_half_h, target_vel_x, target_vel_y,
		output ready
	);
endinterface

interface sbcr_resp_if #(
	parameter int COORD_WIDTH    = sbcr_pkg::SBCR_COORD_WIDTH,
	parameter int TIME_FRAC_BITS = sbcr_pkg::SBCR_TIME_FRAC_BITS
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [TIME_FRAC_BITS:0]       hit_time;
	logic [1:0]                    normal_code;
	logic signed [COORD_WIDTH-1:0] resolved_vel_x;
	logic signed [COORD_WIDTH-1:0] resolved_vel_y;

	modport source (
		output valid, hit, hit_time, normal_code, resolved_vel_x, resolved_vel_y,
		input  ready
	);
	modport sink (
		input  valid, hit, hit_time, normal_code, resolved_vel_x, resolved_vel_y,
		output ready
	);
endinterface

### rtl/sbcr_div.sv
// Pipelined restoring divider for one slab time: the integer bit in the first
// stage, then one fraction bit per stage.
module sbcr_div #(
	parameter int COORD_WIDTH    = sbcr_pkg::SBCR_COORD_WIDTH,
	parameter int TIME_FRAC_BITS = sbcr_pkg::SBCR_TIME_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [COORD_WIDTH+1:0]    mag,
	input  logic [COORD_WIDTH-1:0]    den,
	input  logic                      neg,
	output logic [TIME_FRAC_BITS:0]   quo,
	output logic                      rem_nz,
	output logic                      neg_out,
	output logic                      sat
);
	localparam int W = COORD_WIDTH;
	localparam int F = TIME_FRAC_BITS;

	logic [F:0]   q_s   [0:F];
	logic [W-1:0] rem_s [0:F];
	logic [W-1:0] den_s [0:F];
	logic         neg_s [0:F];
	logic         sat_s [0:F];

	logic         q0;
	logic [W:0]   rem0;

	assign q0   = mag[W:0] >= {1'b0, den};
	assign rem0 = mag[W:0] - (q0 ? {1'b0, den} : '0);

	always_ff @(posedge clk) begin
		if (en) begin
			// Quotients of 2.0 or more saturate; the rest is ignored then.
			sat_s[0] <= mag >= {1'b0, den, 1'b0};
			q_s[0]   <= {{F{1'b0}}, q0};
			rem_s[0] <= rem0[W-1:0];
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k <= F; k++) begin : g_step
		logic [W:0] r2;
		logic       ge;
		logic [W:0] diff;

		assign r2   = {rem_s[k-1], 1'b0};
		assign ge   = r2 >= {1'b0, den_s[k-1]};
		assign diff = r2 - {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k]   <= {q_s[k-1][F-1:0], ge};
				rem_s[k] <= ge ? diff[W-1:0] : r2[W-1:0];
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	assign quo     = q_s[F];
	assign rem_nz  = |rem_s[F];
	assign neg_out = neg_s[F];
	assign sat     = sat_s[F];

endmodule

### rtl/swept_box_collision_response.sv
// Swept box collision with velocity response.
// The pair channel takes one item per cycle: a moving box and a target box,
// each with centre, half extents and displacement per step. The result channel
// gives one item per pair: hit flag, entry time (1 << TIME_FRAC_BITS is 1.0),
// contact normal code and the mover displacement after response, saturated.
// Two front stages form the relative motion and slab edges, four lane
// dividers take TIME_FRAC_BITS + 1 stages, one quotient bit per stage, and
// five stages order the times, test for the hit, multiply and saturate.
// Throughput is one item per cycle. The whole pipeline advances together; when
// the receiver holds ready low with a result waiting, every stage holds and
// pair.ready drops in the same cycle, so nothing is lost or repeated.
// Reset clears all valid bits; the result channel shows no item after reset.
module swept_box_collision_response #(
	parameter int COORD_WIDTH    = sbcr_pkg::SBCR_COORD_WIDTH,
	parameter int TIME_FRAC_BITS = sbcr_pkg::SBCR_TIME_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	sbcr_pair_if.sink   pair,
	sbcr_resp_if.source result
);
	localparam int W  = COORD_WIDTH;
	localparam int F  = TIME_FRAC_BITS;
	localparam int LW = W + 3;
	localparam int DW = W + 1;
	localparam int MW = W + 2;
	localparam int TW = F + 3;

	localparam logic signed [TW-1:0] TLIM = TW'(2) << F;
	localparam logic signed [TW-1:0] TONE = TW'(1) << F;

	typedef struct packed {
		logic signed [W-1:0] mvx;
		logic signed [W-1:0] mvy;
		logic                rvx_neg;
		logic                rvx_zero;
		logic                rvy_neg;
		logic                rvy_zero;
		logic                in_x;
		logic                in_y;
	} side_t;

	logic en;
	assign en         = !result.valid || result.ready;
	assign pair.ready = en;

	// ---------------- stage 1: relative motion and widened slab edges
	logic [W-1:0]         ext_x, ext_y;
	logic                 valid_s1;
	logic signed [LW-1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;
	logic signed [DW-1:0] rvx_s1, rvy_s1;
	logic signed [W-1:0]  mvx_s1, mvy_s1;

	assign ext_x = {1'b0, pair.target_half_w} + {1'b0, pair.mover_half_w};
	assign ext_y = {1'b0, pair.target_half_h} + {1'b0, pair.mover_half_h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_x_s1 <= {{3{pair.target_x[W-1]}}, pair.target_x} - {3'b0, ext_x}
			         - {{3{pair.mover_x[W-1]}}, pair.mover_x};
			hi_x_s1 <= {{3{pair.target_x[W-1]}}, pair.target_x} + {3'b0, ext_x}
			         - {{3{pair.mover_x[W-1]}}, pair.mover_x};
			lo_y_s1 <= {{3{pair.target_y[W-1]}}, pair.target_y} - {3'b0, ext_y}
			         - {{3{pair.mover_y[W-1]}}, pair.mover_y};
			hi_y_s1 <= {{3{pair.target_y[W-1]}}, pair.target_y} + {3'b0, ext_y}
			         - {{3{pair.mover_y[W-1]}}, pair.mover_y};
			rvx_s1  <= {pair.mover_vel_x[W-1], pair.mover_vel_x}
			         - {pair.target_vel_x[W-1], pair.target_vel_x};
			rvy_s1  <= {pair.mover_vel_y[W-1], pair.mover_vel_y}
			         - {pair.target_vel_y[W-1], pair.target_vel_y};
			mvx_s1  <= pair.mover_vel_x;
			mvy_s1  <= pair.mover_vel_y;
		end
	end

	// ---------------- stage 2: magnitudes and signs for the dividers
	// Lanes: 0 x low edge, 1 x high edge, 2 y low edge, 3 y high edge.
	logic signed [LW-1:0] edge_s1 [0:3];
	logic signed [LW-1:0] edge_abs [0:3];
	logic signed [DW-1:0] rvx_abs, rvy_abs;
	logic                 valid_s2;
	logic [MW-1:0]        mag_s2 [0:3];
	logic                 neg_s2 [0:3];
	logic [W-1:0]         den_x_s2, den_y_s2;
	side_t                side_s2;

	assign edge_s1[0] = lo_x_s1;
	assign edge_s1[1] = hi_x_s1;
	assign edge_s1[2] = lo_y_s1;
	assign edge_s1[3] = hi_y_s1;
	assign rvx_abs    = rvx_s1[DW-1] ? -rvx_s1 : rvx_s1;
	assign rvy_abs    = rvy_s1[DW-1] ? -rvy_s1 : rvy_s1;

	for (genvar i = 0; i < 4; i++) begin : g_abs
		assign edge_abs[i] = edge_s1[i][LW-1] ? -edge_s1[i] : edge_s1[i];
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s2[i] <= edge_abs[i][MW-1:0];
				// The time is negative when the edge and the motion disagree in sign.
				neg_s2[i] <= edge_s1[i][LW-1] ^ (i < 2 ? rvx_s1[DW-1] : rvy_s1[DW-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_x_s2         <= rvx_abs[W-1:0];
			den_y_s2         <= rvy_abs[W-1:0];
			side_s2.mvx      <= mvx_s1;
			side_s2.mvy      <= mvy_s1;
			side_s2.rvx_neg  <= rvx_s1[DW-1];
			side_s2.rvx_zero <= rvx_s1 == '0;
			side_s2.rvy_neg  <= rvy_s1[DW-1];
			side_s2.rvy_zero <= rvy_s1 == '0;
			side_s2.in_x     <= lo_x_s1[LW-1] && !hi_x_s1[LW-1] && hi_x_s1 != '0;
			side_s2.in_y     <= lo_y_s1[LW-1] && !hi_y_s1[LW-1] && hi_y_s1 != '0;
		end
	end

	// ---------------- divider lanes, side data delayed alongside
	logic [F:0] quo [0:3];
	logic       rem_nz [0:3];
	logic       qneg [0:3];
	logic       qsat [0:3];

	for (genvar i = 0; i < 4; i++) begin : g_lane
		sbcr_div #(
			.COORD_WIDTH   (W),
			.TIME_FRAC_BITS(F)
		) u_div (
			.clk    (clk),
			.en     (en),
			.mag    (mag_s2[i]),
			.den    (i < 2 ? den_x_s2 : den_y_s2),
			.neg    (neg_s2[i]),
			.quo    (quo[i]),
			.rem_nz (rem_nz[i]),
			.neg_out(qneg[i]),
			.sat    (qsat[i])
		);
	end

	side_t side_d  [0:F];
	logic  valid_d [0:F];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= F; k++) begin
				valid_d[k] <= 1'b0;
			end
		end else if (en) begin
			valid_d[0] <= valid_s2;
			for (int k = 1; k <= F; k++) begin
				valid_d[k] <= valid_d[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= side_s2;
			for (int k = 1; k <= F; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// ---------------- stage 3: signed, floored and saturated slab times
	logic signed [TW-1:0] tq [0:3];
	logic signed [TW-1:0] t_s3 [0:3];
	logic                 valid_s3;
	side_t                side_s3;

	for (genvar i = 0; i < 4; i++) begin : g_time
		assign tq[i] = {2'b00, quo[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (qsat[i]) begin
					t_s3[i] <= qneg[i] ? -TLIM : TLIM;
				end else if (qneg[i]) begin
					t_s3[i] <= -(tq[i] + TW'(rem_nz[i]));
				end else begin
					t_s3[i] <= tq[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_d[F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_d[F];
		end
	end

	// ---------------- stage 4: entry and exit per axis
	logic                 valid_s4;
	logic signed [TW-1:0] tx1_s4, tx2_s4, ty1_s4, ty2_s4;
	logic                 ok_s4;
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			// A still axis spans all time only when the mover is strictly inside.
			if (side_s3.rvx_zero) begin
				tx1_s4 <= -TLIM;
				tx2_s4 <= TLIM;
			end else begin
				tx1_s4 <= t_s3[0] < t_s3[1] ? t_s3[0] : t_s3[1];
				tx2_s4 <= t_s3[0] < t_s3[1] ? t_s3[1] : t_s3[0];
			end
			if (side_s3.rvy_zero) begin
				ty1_s4 <= -TLIM;
				ty2_s4 <= TLIM;
			end else begin
				ty1_s4 <= t_s3[2] < t_s3[3] ? t_s3[2] : t_s3[3];
				ty2_s4 <= t_s3[2] < t_s3[3] ? t_s3[3] : t_s3[2];
			end
			ok_s4 <= !(side_s3.rvx_zero && side_s3.rvy_zero)
			      && (!side_s3.rvx_zero || side_s3.in_x)
			      && (!side_s3.rvy_zero || side_s3.in_y);
		end
	end

	// ---------------- stage 5: hit decision, normal and response factor
	logic signed [TW-1:0] tnear;
	logic                 hit_c, axis_x;
	logic signed [W-1:0]  vsel;
	logic signed [W-1:0]  vneg;
	logic signed [TW-1:0] mfac;

	logic                 valid_s5, hit_s5, axis_x_s5, pos_s5;
	logic [F:0]           time_s5;
	sbcr_pkg::normal_t    code_s5;
	logic [W-1:0]         vmag_s5;
	logic [F:0]           m_s5;
	logic signed [W-1:0]  mvx_s5, mvy_s5;

	assign tnear  = tx1_s4 > ty1_s4 ? tx1_s4 : ty1_s4;
	assign axis_x = tx1_s4 >= ty1_s4;
	assign hit_c  = ok_s4 && !tnear[TW-1] && tnear <= TONE
	             && !(tx1_s4 > ty2_s4) && !(ty1_s4 > tx2_s4)
	             && !tx2_s4[TW-1] && !ty2_s4[TW-1];
	assign vsel   = axis_x ? side_s4.mvx : side_s4.mvy;
	assign vneg   = -vsel;
	assign mfac   = TONE - tnear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5    <= hit_c;
			axis_x_s5 <= axis_x;
			pos_s5    <= axis_x ? side_s4.rvx_neg : side_s4.rvy_neg;
			time_s5   <= hit_c ? tnear[F:0] : '0;
			if (!hit_c) begin
				code_s5 <= sbcr_pkg::NORMAL_POS_X;
			end else if (axis_x) begin
				code_s5 <= side_s4.rvx_neg ? sbcr_pkg::NORMAL_POS_X : sbcr_pkg::NORMAL_NEG_X;
			end else begin
				code_s5 <= side_s4.rvy_neg ? sbcr_pkg::NORMAL_POS_Y : sbcr_pkg::NORMAL_NEG_Y;
			end
			vmag_s5   <= vsel[W-1] ? vneg : vsel;
			m_s5      <= mfac[F:0];
			mvx_s5    <= side_s4.mvx;
			mvy_s5    <= side_s4.mvy;
		end
	end

	// ---------------- stage 6: |v| * (1 - t)
	logic [W+F:0]        prod;
	logic                valid_s6, hit_s6, axis_x_s6, pos_s6;
	logic [F:0]          time_s6;
	sbcr_pkg::normal_t   code_s6;
	logic [W-1:0]        dv_s6;
	logic signed [W-1:0] mvx_s6, mvy_s6;

	assign prod = vmag_s5 * m_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s6    <= hit_s5;
			axis_x_s6 <= axis_x_s5;
			pos_s6    <= pos_s5;
			time_s6   <= time_s5;
			code_s6   <= code_s5;
			dv_s6     <= prod[W+F-1:F];
			mvx_s6    <= mvx_s5;
			mvy_s6    <= mvy_s5;
		end
	end

	// ---------------- stage 7: response add with saturation, output register
	localparam logic signed [W+1:0] SMAX = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SMIN = {3'b111, {(W-1){1'b0}}};

	logic signed [W-1:0] vbase;
	logic signed [W+1:0] vsum;
	logic signed [W-1:0] vsat;

	assign vbase = axis_x_s6 ? mvx_s6 : mvy_s6;
	assign vsum  = pos_s6 ? {{2{vbase[W-1]}}, vbase} + {2'b00, dv_s6}
	                      : {{2{vbase[W-1]}}, vbase} - {2'b00, dv_s6};
	assign vsat  = vsum > SMAX ? SMAX[W-1:0] : (vsum < SMIN ? SMIN[W-1:0] : vsum[W-1:0]);

	logic                valid_s7, hit_s7;
	logic [F:0]          time_s7;
	sbcr_pkg::normal_t   code_s7;
	logic signed [W-1:0] ox_s7, oy_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s7  <= hit_s6;
			time_s7 <= time_s6;
			code_s7 <= code_s6;
			ox_s7   <= (hit_s6 && axis_x_s6) ? vsat : mvx_s6;
			oy_s7   <= (hit_s6 && !axis_x_s6) ? vsat : mvy_s6;
		end
	end

	assign result.valid          = valid_s7;
	assign result.hit            = hit_s7;
	assign result.hit_time       = time_s7;
	assign result.normal_code    = code_s7;
	assign result.resolved_vel_x = ox_s7;
	assign result.resolved_vel_y = oy_s7;

endmodule

### rtl/sbcr_checker.sv
module sbcr_checker #(
	parameter int TIME_FRAC_BITS = sbcr_pkg::SBCR_TIME_FRAC_BITS
) (
	input logic         clk,
	input logic         arst_n,
	sbcr_pair_if.sink   pair,
	sbcr_resp_if.source result
);
	localparam logic [TIME_FRAC_BITS:0] TONE = (TIME_FRAC_BITS + 1)'(1) << TIME_FRAC_BITS;

	// The pipeline takes an item exactly when it can move forward.
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		pair.ready == (!result.valid || result.ready))
		else $error("pair.ready does not follow the output stall");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.hit)
			&& $stable(result.hit_time) && $stable(result.resolved_vel_x)
			&& $stable(result.resolved_vel_y))
		else $error("stalled result item changed");

	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.hit |->
			result.hit_time == '0 && result.normal_code == sbcr_pkg::NORMAL_POS_X)
		else $error("miss item carries a time or a normal");

	a_hit_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.hit |-> result.hit_time <= TONE)
		else $error("hit time beyond one step");

endmodule

bind swept_box_collision_response sbcr_checker #(
	.TIME_FRAC_BITS(TIME_FRAC_BITS)
) u_sbcr_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.pair  (pair),
	.result(result)
);
